[hdl/e2cd_pkg.sv]
// ----------------------------------------------------------------------------
// e2cd_pkg: shared types, constants and calendar helpers
// Holds the controller/datapath command set, the status bundle, the divider
// constants and the Gregorian leap and month-length functions.
// ----------------------------------------------------------------------------
package e2cd_pkg;

	localparam int unsigned EPOCH_W = 32;
	localparam int unsigned REM_W   = 17;
	localparam int unsigned DAYS_W  = 16;

	localparam logic [REM_W-1:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [REM_W-1:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [REM_W-1:0] SECS_PER_MIN  = 17'd60;
	localparam logic [REM_W-1:0] DAYS_PER_WEEK = 17'd7;

	// Reciprocals for exact division by constants after a pre-shift:
	// 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15.
	localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // ceil(2^35 / 675)
	localparam logic [13:0] HOUR_RECIP = 14'd9321;      // ceil(2^21 / 225)
	localparam logic [10:0] MIN_RECIP  = 11'd1093;      // ceil(2^14 / 15)
	localparam logic [16:0] WEEK_RECIP = 17'd74899;     // ceil(2^19 / 7)

	localparam logic [7:0]        EPOCH_YEAR_OFS = 8'd70;   // 1970 - 1900
	localparam logic [DAYS_W-1:0] WEEKDAY_OFS    = 16'd4;   // day 0 was a Thursday
	localparam logic [3:0]        LAST_MONTH     = 4'd11;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_QUO_DAY,
		OP_SAVE_DAY,
		OP_QUO_HOUR,
		OP_SAVE_HOUR,
		OP_QUO_MIN,
		OP_SAVE_MIN,
		OP_QUO_WEEK,
		OP_SAVE_WEEK,
		OP_YEAR,
		OP_MONTH_INIT,
		OP_MONTH,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		logic div_done;
		logic year_more;
		logic month_more;
	} dp_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_DAY,
		ST_DIV_HOUR,
		ST_DIV_MIN,
		ST_DIV_WEEK,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} ctrl_state_t;

	// Years 1970..2106 as offsets from 1900: only 2000 and 2100 are centuries.
	function automatic logic is_leap(input logic [7:0] yofs);
		return (yofs[1:0] == 2'd0) && (yofs != 8'd200);
	endfunction

	function automatic logic [8:0] year_len(input logic [7:0] yofs);
		return is_leap(yofs) ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
		logic [4:0] len;
		unique case (mon)
			4'd1:                      len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

[hdl/epoch_to_calendar_date.sv]
// ----------------------------------------------------------------------------
// epoch_to_calendar_date: seconds since 1970-01-01 UTC to calendar time
// Usage:
//   Input channel in_valid/in_ready carries epoch_seconds, an unsigned 32-bit
//   count of seconds. Output channel out_valid/out_ready carries second,
//   minute, hour, weekday (0 is Sunday), years_since_1900, day_of_year,
//   month (0 is January) and day_of_month (from 1). One transfer out for
//   every transfer in, in order.
//   Sequence: the load, then for each of the day, hour, minute and weekday
//   splits a reciprocal multiply, then a multiply-back for the remainder;
//   then one year step per whole year past 1970 and one more, one month
//   step per whole month and one more, and the publish. The year
//   subtraction loop sets most of the run time.
//   One item at a time: in_ready is high only while idle, so a new item enters
//   only after the last one is published, and it may enter while the previous
//   result still waits in the output register.
//   Reset (arst_n low) returns to idle and drops any waiting result.
//   When the receiver stalls, the result holds in the output register and a
//   finished second item waits in the sequencer until the first is taken.
// ----------------------------------------------------------------------------
module epoch_to_calendar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  second,
	output logic [5:0]  minute,
	output logic [4:0]  hour,
	output logic [2:0]  weekday,
	output logic [7:0]  years_since_1900,
	output logic [8:0]  day_of_year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month
);

	e2cd_pkg::dp_op_t     op;
	e2cd_pkg::dp_status_t status;

	// Sequencer: owns both handshakes and issues at most one datapath command per cycle.
	e2cd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.op        (op)
	);

	// Datapath: divider, year/month loops and the output holding register.
	e2cd_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.epoch_seconds    (epoch_seconds),
		.status           (status),
		.second           (second),
		.minute           (minute),
		.hour             (hour),
		.weekday          (weekday),
		.years_since_1900 (years_since_1900),
		.day_of_year      (day_of_year),
		.month            (month),
		.day_of_month     (day_of_month)
	);

`ifndef SYNTHESIS
	// A transfer in starts a conversion: no second transfer the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted twice in a row");

	// Time of day fields stay in range whenever a result is offered.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> second < 6'd60 && minute < 6'd60 && hour < 5'd24 && weekday < 3'd7)
		else $error("time of day field out of range");

	// Date fields stay in range whenever a result is offered.
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> month < 4'd12 && day_of_month != 5'd0 && day_of_year < 9'd366
			&& years_since_1900 >= 8'd70 && years_since_1900 <= 8'd206)
		else $error("date field out of range");

	// A publish only happens into an empty or draining output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		op == e2cd_pkg::OP_PUBLISH |-> !out_valid || out_ready)
		else $error("waiting result overwritten");
`endif

endmodule

[hdl/e2cd_dp.sv]
// ----------------------------------------------------------------------------
// e2cd_dp: conversion datapath
// Reciprocal-multiply division by the day, hour, minute and week constants,
// year and month subtraction registers and the output holding register.
// ----------------------------------------------------------------------------
module e2cd_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  e2cd_pkg::dp_op_t    op,
	input  logic [31:0]         epoch_seconds,
	output e2cd_pkg::dp_status_t status,
	output logic [5:0]          second,
	output logic [5:0]          minute,
	output logic [4:0]          hour,
	output logic [2:0]          weekday,
	output logic [7:0]          years_since_1900,
	output logic [8:0]          day_of_year,
	output logic [3:0]          month,
	output logic [4:0]          day_of_month
);

	logic [e2cd_pkg::EPOCH_W-1:0] num_q;
	logic [e2cd_pkg::DAYS_W-1:0]  quo_q;
	logic                         quo_ok_q;
	logic [e2cd_pkg::DAYS_W-1:0]  days_q;
	logic [e2cd_pkg::DAYS_W-1:0]  left_q;
	logic [7:0]                   year_q;
	logic [3:0]                   mon_q;
	logic [8:0]                   yday_q;
	logic [5:0]                   sec_q;
	logic [5:0]                   min_q;
	logic [4:0]                   hour_q;
	logic [2:0]                   wday_q;

	logic [50:0]                  day_prod;
	logic [26:0]                  hour_prod;
	logic [20:0]                  min_prod;
	logic [32:0]                  week_prod;
	logic [e2cd_pkg::REM_W-1:0]   dsor;
	logic [32:0]                  back_prod;
	logic [e2cd_pkg::EPOCH_W-1:0] rem_full;
	logic [8:0]                   ylen;
	logic [4:0]                   mlen;

	// Quotients: pre-shift by the power-of-two factor, multiply, keep the top.
	assign day_prod  = {26'd0, num_q[31:7]} * {25'd0, e2cd_pkg::DAY_RECIP};
	assign hour_prod = {14'd0, num_q[16:4]} * {13'd0, e2cd_pkg::HOUR_RECIP};
	assign min_prod  = {11'd0, num_q[11:2]} * {10'd0, e2cd_pkg::MIN_RECIP};
	assign week_prod = {17'd0, num_q[15:0]} * {16'd0, e2cd_pkg::WEEK_RECIP};

	// Remainder: multiply the held quotient back and subtract.
	always_comb begin
		unique case (op)
			e2cd_pkg::OP_SAVE_DAY:  dsor = e2cd_pkg::SECS_PER_DAY;
			e2cd_pkg::OP_SAVE_HOUR: dsor = e2cd_pkg::SECS_PER_HOUR;
			e2cd_pkg::OP_SAVE_MIN:  dsor = e2cd_pkg::SECS_PER_MIN;
			default:                dsor = e2cd_pkg::DAYS_PER_WEEK;
		endcase
	end

	assign back_prod = {17'd0, quo_q} * {16'd0, dsor};
	assign rem_full  = num_q - back_prod[31:0];

	assign ylen = e2cd_pkg::year_len(year_q);
	assign mlen = e2cd_pkg::month_len(e2cd_pkg::is_leap(year_q), mon_q);

	assign status.div_done   = quo_ok_q;
	assign status.year_more  = left_q >= {7'd0, ylen};
	assign status.month_more = (mon_q < e2cd_pkg::LAST_MONTH) && (left_q >= {11'd0, mlen});

	// Quotient-ready flag is control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_ok_q <= 1'b0;
		end else begin
			unique case (op)
				e2cd_pkg::OP_QUO_DAY, e2cd_pkg::OP_QUO_HOUR,
				e2cd_pkg::OP_QUO_MIN, e2cd_pkg::OP_QUO_WEEK: quo_ok_q <= 1'b1;
				default:                                     quo_ok_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			e2cd_pkg::OP_LOAD: begin
				num_q <= epoch_seconds;
			end
			e2cd_pkg::OP_QUO_DAY: begin
				quo_q <= day_prod[50:35];
			end
			e2cd_pkg::OP_SAVE_DAY: begin
				days_q <= quo_q;
				num_q  <= rem_full;
			end
			e2cd_pkg::OP_QUO_HOUR: begin
				quo_q <= {11'd0, hour_prod[25:21]};
			end
			e2cd_pkg::OP_SAVE_HOUR: begin
				hour_q <= quo_q[4:0];
				num_q  <= rem_full;
			end
			e2cd_pkg::OP_QUO_MIN: begin
				quo_q <= {10'd0, min_prod[19:14]};
			end
			e2cd_pkg::OP_SAVE_MIN: begin
				min_q <= quo_q[5:0];
				sec_q <= rem_full[5:0];
				num_q <= {16'd0, days_q + e2cd_pkg::WEEKDAY_OFS};
			end
			e2cd_pkg::OP_QUO_WEEK: begin
				quo_q <= {3'd0, week_prod[31:19]};
			end
			e2cd_pkg::OP_SAVE_WEEK: begin
				wday_q <= rem_full[2:0];
				year_q <= e2cd_pkg::EPOCH_YEAR_OFS;
				left_q <= days_q;
			end
			e2cd_pkg::OP_YEAR: begin
				left_q <= left_q - {7'd0, ylen};
				year_q <= year_q + 8'd1;
			end
			e2cd_pkg::OP_MONTH_INIT: begin
				yday_q <= left_q[8:0];
				mon_q  <= '0;
			end
			e2cd_pkg::OP_MONTH: begin
				left_q <= left_q - {11'd0, mlen};
				mon_q  <= mon_q + 4'd1;
			end
			e2cd_pkg::OP_PUBLISH: begin
				second           <= sec_q;
				minute           <= min_q;
				hour             <= hour_q;
				weekday          <= wday_q;
				years_since_1900 <= year_q;
				day_of_year      <= yday_q;
				month            <= mon_q;
				day_of_month     <= left_q[4:0] + 5'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/e2cd_ctrl.sv]
// ----------------------------------------------------------------------------
// e2cd_ctrl: conversion sequencer
// Walks the datapath through the four divisions, the year and month loops
// and the hand-off to the output register; owns both handshakes.
// ----------------------------------------------------------------------------
module e2cd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  e2cd_pkg::dp_status_t status,
	output e2cd_pkg::dp_op_t     op
);

	e2cd_pkg::ctrl_state_t state_q;
	e2cd_pkg::ctrl_state_t state_next;
	logic                  out_valid_q;
	logic                  publish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= e2cd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		op         = e2cd_pkg::OP_NONE;
		in_ready   = 1'b0;
		publish    = 1'b0;
		unique case (state_q)
			e2cd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op         = e2cd_pkg::OP_LOAD;
					state_next = e2cd_pkg::ST_DIV_DAY;
				end
			end
			e2cd_pkg::ST_DIV_DAY: begin
				if (status.div_done) begin
					op         = e2cd_pkg::OP_SAVE_DAY;
					state_next = e2cd_pkg::ST_DIV_HOUR;
				end else begin
					op = e2cd_pkg::OP_QUO_DAY;
				end
			end
			e2cd_pkg::ST_DIV_HOUR: begin
				if (status.div_done) begin
					op         = e2cd_pkg::OP_SAVE_HOUR;
					state_next = e2cd_pkg::ST_DIV_MIN;
				end else begin
					op = e2cd_pkg::OP_QUO_HOUR;
				end
			end
			e2cd_pkg::ST_DIV_MIN: begin
				if (status.div_done) begin
					op         = e2cd_pkg::OP_SAVE_MIN;
					state_next = e2cd_pkg::ST_DIV_WEEK;
				end else begin
					op = e2cd_pkg::OP_QUO_MIN;
				end
			end
			e2cd_pkg::ST_DIV_WEEK: begin
				if (status.div_done) begin
					op         = e2cd_pkg::OP_SAVE_WEEK;
					state_next = e2cd_pkg::ST_YEAR;
				end else begin
					op = e2cd_pkg::OP_QUO_WEEK;
				end
			end
			e2cd_pkg::ST_YEAR: begin
				if (status.year_more) begin
					op = e2cd_pkg::OP_YEAR;
				end else begin
					op         = e2cd_pkg::OP_MONTH_INIT;
					state_next = e2cd_pkg::ST_MONTH;
				end
			end
			e2cd_pkg::ST_MONTH: begin
				if (status.month_more) begin
					op = e2cd_pkg::OP_MONTH;
				end else begin
					state_next = e2cd_pkg::ST_DONE;
				end
			end
			e2cd_pkg::ST_DONE: begin
				// Hand over once the output register is empty or emptying.
				if (!out_valid_q || out_ready) begin
					op         = e2cd_pkg::OP_PUBLISH;
					publish    = 1'b1;
					state_next = e2cd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = e2cd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: epoch_to_calendar_date self-checking testbench
// Drives 32-bit epoch seconds through the valid/ready input channel and checks
// every calendar result against a behavioral converter. Directed corner times
// come first: day, hour and year edges, leap days, the year 2100 and the 32-bit
// end. Random times follow, with random idling on both channels, a long
// receiver hold-off and a drain pause.
// ----------------------------------------------------------------------------

typedef struct {
	logic [5:0] second;
	logic [5:0] minute;
	logic [4:0] hour;
	logic [2:0] weekday;
	logic [7:0] years_since_1900;
	logic [8:0] day_of_year;
	logic [3:0] month;
	logic [4:0] day_of_month;
} calendar_t;

class calendar_scoreboard;
	calendar_t expected_dates[$];
	int unsigned mismatches;

	function new();
		mismatches = 0;
	endfunction

	function bit is_leap_year(int unsigned yr);
		return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
	endfunction

	// Broken-down UTC time for an epoch value.
	function calendar_t civil_from_epoch(logic [31:0] t);
		calendar_t r;
		int unsigned sod, days, yr, mon, ylen, mlen;
		int unsigned mdays[12];
		mdays = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		sod = t % 86400;
		days = t / 86400;
		r.second = 6'(sod % 60);
		r.minute = 6'((sod % 3600) / 60);
		r.hour = 5'(sod / 3600);
		r.weekday = 3'((days + 4) % 7);
		yr = 1970;
		ylen = is_leap_year(yr) ? 366 : 365;
		while (days >= ylen) begin
			days -= ylen;
			yr++;
			ylen = is_leap_year(yr) ? 366 : 365;
		end
		r.years_since_1900 = 8'(yr - 1900);
		r.day_of_year = 9'(days);
		if (is_leap_year(yr))
			mdays[1] = 29;
		mon = 0;
		mlen = mdays[0];
		while (mon < 11 && days >= mlen) begin
			days -= mlen;
			mon++;
			mlen = mdays[mon];
		end
		r.month = 4'(mon);
		r.day_of_month = 5'(days + 1);
		return r;
	endfunction

	function void note_epoch(logic [31:0] t);
		expected_dates.push_back(civil_from_epoch(t));
	endfunction

	function void check_result(calendar_t got);
		calendar_t exp;
		bit bad;
		if (expected_dates.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: unexpected result %0d:%0d:%0d y%0d m%0d d%0d",
					got.hour, got.minute, got.second,
					got.years_since_1900, got.month, got.day_of_month);
			return;
		end
		exp = expected_dates.pop_front();
		bad = (got.second !== exp.second) || (got.minute !== exp.minute)
			|| (got.hour !== exp.hour) || (got.weekday !== exp.weekday)
			|| (got.years_since_1900 !== exp.years_since_1900)
			|| (got.day_of_year !== exp.day_of_year)
			|| (got.month !== exp.month) || (got.day_of_month !== exp.day_of_month);
		if (bad) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("ERROR: expected s%0d m%0d h%0d wd%0d y%0d yd%0d mo%0d md%0d",
					exp.second, exp.minute, exp.hour, exp.weekday,
					exp.years_since_1900, exp.day_of_year, exp.month,
					exp.day_of_month);
				$display("       actual   s%0d m%0d h%0d wd%0d y%0d yd%0d mo%0d md%0d",
					got.second, got.minute, got.hour, got.weekday,
					got.years_since_1900, got.day_of_year, got.month,
					got.day_of_month);
			end
		end
	endfunction

	function int unsigned pending();
		return expected_dates.size();
	endfunction
endclass

module tb;

	localparam int unsigned RANDOM_ITEMS = 630;
	localparam int unsigned HOLD_CYCLES  = 1000;  // long enough to back up the input
	localparam int unsigned DRAIN_CYCLES = 300;   // beyond the slowest item latency

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] epoch_seconds;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  second;
	logic [5:0]  minute;
	logic [4:0]  hour;
	logic [2:0]  weekday;
	logic [7:0]  years_since_1900;
	logic [8:0]  day_of_year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;

	calendar_scoreboard sb = new();

	// Idling switch shared by sender and receiver; cleared for quiet stretches
	// and for the tail of the run.
	bit idling_on;
	// Sender asks the receiver for one long hold-off.
	bit hold_req;

	epoch_to_calendar_date dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.epoch_seconds    (epoch_seconds),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.second           (second),
		.minute           (minute),
		.hour             (hour),
		.weekday          (weekday),
		.years_since_1900 (years_since_1900),
		.day_of_year      (day_of_year),
		.month            (month),
		.day_of_month     (day_of_month)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit: several times the slowest legal run.
	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Offer one time value and hold it until the transfer happens. An optional
	// gap first drops valid for a random burst of cycles.
	task automatic offer_epoch(input logic [31:0] t);
		int unsigned gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		epoch_seconds <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold until every expected result has come back. The check follows a clock
	// edge, so the monitor has noted the last transfer in.
	task automatic wait_drained();
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Watch both channels at each rising edge. Values read here are the ones
	// the block saw at that edge, since all drives land later as nonblocking
	// updates.
	always @(posedge clk) begin
		calendar_t got;
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_epoch(epoch_seconds);
			if (out_valid && out_ready) begin
				got.second = second;
				got.minute = minute;
				got.hour = hour;
				got.weekday = weekday;
				got.years_since_1900 = years_since_1900;
				got.day_of_year = day_of_year;
				got.month = month;
				got.day_of_month = day_of_month;
				sb.check_result(got);
			end
		end
	end

	// Receiver: random stall bursts while idling is on, plus one long
	// hold-off on request. Each path raises ready again only on a later edge
	// than the one that lowered it.
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 16);
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Sender and run control.
	initial begin
		logic [31:0] corner_times[$];
		logic [31:0] t;
		logic [63:0] wide;
		int unsigned day;
		in_valid = 1'b0;
		epoch_seconds = '0;
		arst_n = 1'b0;
		idling_on = 1'b1;
		hold_req = 1'b0;

		// Edges of minute, hour, day and year; leap days in 1972 and 2000;
		// the last day of a leap year; 2100, a century that is not leap; the
		// signed 32-bit rollover; the largest value; alternating bit patterns.
		corner_times = '{
			32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600,
			32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
			32'd68169600, 32'd94608000, 32'd94694400,
			32'd951782400, 32'd978220799, 32'd978220800,
			32'd2147483647, 32'd2147483648,
			32'd4102444799, 32'd4102444800, 32'd4107542399, 32'd4107542400,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_times[i])
			offer_epoch(corner_times[i]);

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			// Pause the sender once until the block has emptied out.
			if (n == 120) begin
				in_valid <= 1'b0;
				wait_drained();
				@(posedge clk);
			end
			// Ask for the long hold-off and keep offering behind it.
			if (n == 200)
				hold_req = 1'b1;
			// A quiet stretch mid-run, and none for the last part.
			idling_on = !((n >= 300 && n < 360) || n >= RANDOM_ITEMS - 100);

			case ($urandom_range(0, 4))
				0, 1: t = $urandom();
				2: begin
					// Near a day edge, any year.
					day = $urandom_range(0, 49710);
					case ($urandom_range(0, 3))
						0: wide = 64'(day) * 86400;
						1: wide = 64'(day) * 86400 + 86399;
						2: wide = 64'(day) * 86400 + 1;
						default: wide = 64'(day) * 86400 + $urandom_range(0, 86399);
					endcase
					t = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
				end
				3: t = $urandom_range(0, 3 * 365 * 86400);   // fast, early years
				default: t = 32'hFFFF_FFFF - $urandom_range(0, 40_000_000);
			endcase
			offer_epoch(t);
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/e2cd_pkg.sv
hdl/e2cd_dp.sv
hdl/e2cd_ctrl.sv
hdl/epoch_to_calendar_date.sv
tb/sv/tb.sv
